[src/pleg_pkg.sv]
// ============================================================================
// pleg_pkg
// Shared widths, limits and codes for the piecewise-linear envelope gain.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pleg_pkg;

    localparam int MAX_POINTS    = 16;
    localparam int POSITION_BITS = 24;

    localparam int IDX_W    = $clog2(MAX_POINTS);
    localparam int POS_W    = POSITION_BITS;
    localparam int MODE_W   = 2;
    localparam int SAMPLE_W = 16;
    localparam int PIDX_W   = 4;
    localparam int PPOS_W   = 24;
    localparam int GAIN_W   = 24;
    localparam int CFG_W    = 5;

    localparam int FRAC_BITS = 16;
    localparam int DIFF_W    = GAIN_W + 1;
    localparam int PROD_W    = DIFF_W + POS_W;
    localparam int QUO_W     = DIFF_W;
    localparam int GSUM_W    = QUO_W + 1;
    localparam int SCALE_W   = SAMPLE_W + GAIN_W;
    localparam int Y_W       = SCALE_W - FRAC_BITS;
    localparam int DCNT_W    = $clog2(QUO_W + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE  = 2'd0,
        MODE_LOAD    = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_UNUSED  = 2'd3
    } t_mode;

endpackage

`default_nettype wire

[src/pleg_if.sv]
// ============================================================================
// pleg_if
// Valid/ready channels for input items and result items.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface pleg_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [pleg_pkg::MODE_W-1:0]           mode;
    logic signed [pleg_pkg::SAMPLE_W-1:0]  sample_in;
    logic [pleg_pkg::PIDX_W-1:0]           point_index;
    logic [pleg_pkg::PPOS_W-1:0]           point_position;
    logic signed [pleg_pkg::GAIN_W-1:0]    point_gain;

    modport source (
        output valid, mode, sample_in, point_index, point_position, point_gain,
        input  ready
    );
    modport sink (
        input  valid, mode, sample_in, point_index, point_position, point_gain,
        output ready
    );
endinterface

interface pleg_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pleg_pkg::SAMPLE_W-1:0]  sample_out;
    logic                                  saturated;

    modport source (
        output valid, sample_out, saturated,
        input  ready
    );
    modport sink (
        input  valid, sample_out, saturated,
        output ready
    );
endinterface

`default_nettype wire

[src/pleg_bp_table.sv]
// ============================================================================
// pleg_bp_table
// Breakpoint table: one write port, one read port, cleared by reset.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pleg_bp_table (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_we,
    input  wire logic [pleg_pkg::IDX_W-1:0]         i_waddr,
    input  wire logic [pleg_pkg::POS_W-1:0]         i_wpos,
    input  wire logic signed [pleg_pkg::GAIN_W-1:0] i_wgain,
    input  wire logic [pleg_pkg::IDX_W-1:0]         i_raddr,
    output logic [pleg_pkg::POS_W-1:0]              o_rpos,
    output logic signed [pleg_pkg::GAIN_W-1:0]      o_rgain
);

    logic [pleg_pkg::POS_W-1:0]         r_pos  [pleg_pkg::MAX_POINTS];
    logic signed [pleg_pkg::GAIN_W-1:0] r_gain [pleg_pkg::MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < pleg_pkg::MAX_POINTS; j++) begin
                r_pos[j]  <= '0;
                r_gain[j] <= '0;
            end
        end else if (i_we) begin
            r_pos[i_waddr]  <= i_wpos;
            r_gain[i_waddr] <= i_wgain;
        end
    end

    assign o_rpos  = r_pos[i_raddr];
    assign o_rgain = r_gain[i_raddr];

endmodule

`default_nettype wire

[src/pleg_div.sv]
// ============================================================================
// pleg_div
// Iterative restoring divider, one quotient bit per cycle.
// Dividend high part must be below the divisor (quotient fits QUO_W bits).
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pleg_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [pleg_pkg::PROD_W-1:0]   i_dividend,
    input  wire logic [pleg_pkg::POS_W-1:0]    i_divisor,
    output logic                               o_done,
    output logic [pleg_pkg::QUO_W-1:0]         o_quotient
);

    localparam int PW = pleg_pkg::POS_W;
    localparam int QW = pleg_pkg::QUO_W;

    logic [PW-1:0]               r_rem;
    logic [QW-1:0]               r_low;
    logic [PW-1:0]               r_den;
    logic [pleg_pkg::DCNT_W-1:0] r_cnt;
    logic                        r_done;

    logic [PW:0]   rem_sh;
    logic [PW:0]   rem_sub;
    logic          ge;
    logic [PW-1:0] n_rem;

    always_comb begin
        rem_sh  = {r_rem, r_low[QW-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        ge      = rem_sh >= {1'b0, r_den};
        n_rem   = ge ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem <= i_dividend[pleg_pkg::PROD_W-1:QW];
                r_low <= i_dividend[QW-1:0];
                r_den <= i_divisor;
                r_cnt <= pleg_pkg::DCNT_W'(QW);
            end else if (r_cnt != '0) begin
                r_rem <= n_rem;
                r_low <= {r_low[QW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == pleg_pkg::DCNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_low;

endmodule

`default_nettype wire

[src/piecewise_linear_envelope_gain.sv]
// ============================================================================
// piecewise_linear_envelope_gain
// Scales audio samples by a piecewise-linear gain envelope.
// ============================================================================
// A sample item passes these steps from acceptance until its result is
// registered:
//   - a fetch of the first breakpoint;
//   - a linear scan of the breakpoint table, one entry per cycle, up to
//     points_in_use - 1 entries;
//   - a multiply step, which also starts the divider;
//   - the iterative divider: 25 quotient bits, then the done flag;
//   - the gain add, the sample scaling and the output load.
// A sample outside every segment skips the multiply, divider, gain add and
// scaling steps and goes from the scan straight to the output load.
// The next item is accepted once the sequencer is back in idle after the
// output load. Load, restart and unused-mode items are taken in idle and
// leave the sequencer idle. The input is ready only while
// the sequencer is idle. A finished result waits in the output register, so
// the next item can be accepted meanwhile. A later sample then holds in its
// output step until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_envelope_gain (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [pleg_pkg::CFG_W-1:0]   i_cfg_wr_data,
    pleg_in_if.sink                           i_in,
    pleg_out_if.source                        o_out
);

    localparam int IW = pleg_pkg::IDX_W;
    localparam int PW = pleg_pkg::POS_W;
    localparam int GW = pleg_pkg::GAIN_W;
    localparam int SW = pleg_pkg::SAMPLE_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_GAIN  = 8'b0010_0000,
        S_SCALE = 8'b0100_0000,
        S_PUSH  = 8'b1000_0000
    } t_state;

    t_state              r_state;
    logic [IW-1:0]       r_last;
    logic [PW-1:0]       r_counter;
    logic [IW-1:0]       r_idx;
    logic signed [SW-1:0] r_s;
    logic [PW-1:0]       r_p0;
    logic [PW-1:0]       r_p1;
    logic signed [GW-1:0] r_g0;
    logic signed [GW-1:0] r_g1;
    logic                r_neg;
    logic signed [GW-1:0] r_g;
    logic signed [SW-1:0] r_y;
    logic                r_sat;
    logic                r_out_valid;
    logic signed [SW-1:0] r_out_sample;
    logic                r_out_sat;

    logic                 in_accept;
    logic                 tbl_we;
    logic [PW-1:0]        rd_pos;
    logic signed [GW-1:0] rd_gain;

    logic [pleg_pkg::DIFF_W-1:0] gdiff;
    logic [pleg_pkg::DIFF_W-1:0] gmag;
    logic [PW-1:0]               num;
    logic [PW-1:0]               den;
    logic [pleg_pkg::PROD_W-1:0] prod;
    logic                        div_start;
    logic                        div_done;
    logic [pleg_pkg::QUO_W-1:0]  quo;

    logic [pleg_pkg::GSUM_W-1:0]   q_ext;
    logic [pleg_pkg::GSUM_W-1:0]   q_sgn;
    logic [pleg_pkg::GSUM_W-1:0]   gsum;
    logic signed [pleg_pkg::SCALE_W-1:0] scaled;
    logic [pleg_pkg::Y_W-1:0]      y;
    logic                          ovf;
    logic                          push_ok;
    logic                          push_fire;
    logic                          seg_hit;

    assign in_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign tbl_we = in_accept && (i_in.mode == pleg_pkg::MODE_LOAD)
                    && (32'(i_in.point_index) < pleg_pkg::MAX_POINTS);

    pleg_bp_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (tbl_we),
        .i_waddr (IW'(i_in.point_index)),
        .i_wpos  (PW'(i_in.point_position)),
        .i_wgain (i_in.point_gain),
        .i_raddr (r_idx),
        .o_rpos  (rd_pos),
        .o_rgain (rd_gain)
    );

    always_comb begin
        gdiff = {r_g1[GW-1], r_g1} - {r_g0[GW-1], r_g0};
        gmag  = gdiff[pleg_pkg::DIFF_W-1] ? (~gdiff + 1'b1) : gdiff;
        num   = r_counter - r_p0;
        den   = r_p1 - r_p0;
        prod  = pleg_pkg::PROD_W'(gmag) * pleg_pkg::PROD_W'(num);
    end

    assign div_start = (r_state == S_MUL);

    pleg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod),
        .i_divisor  (den),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    always_comb begin
        q_ext  = {1'b0, quo};
        q_sgn  = r_neg ? (~q_ext + 1'b1) : q_ext;
        gsum   = {{(pleg_pkg::GSUM_W-GW){r_g0[GW-1]}}, r_g0} + q_sgn;
        scaled = r_s * r_g;
        y      = scaled[pleg_pkg::SCALE_W-1:pleg_pkg::FRAC_BITS];
        ovf    = !((&y[pleg_pkg::Y_W-1:SW-1]) || !(|y[pleg_pkg::Y_W-1:SW-1]));
        seg_hit = (r_p0 <= r_counter) && (r_counter < rd_pos);
        push_ok = !r_out_valid || o_out.ready;
    end

    assign push_fire = (r_state == S_PUSH) && push_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= IW'(1);
        end else if (i_cfg_wr_en) begin
            if (32'(i_cfg_wr_data) < 2) begin
                r_last <= IW'(1);
            end else if (32'(i_cfg_wr_data) > pleg_pkg::MAX_POINTS) begin
                r_last <= IW'(pleg_pkg::MAX_POINTS - 1);
            end else begin
                r_last <= IW'(i_cfg_wr_data - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_counter   <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (push_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        case (i_in.mode)
                            pleg_pkg::MODE_SAMPLE: begin
                                r_s     <= i_in.sample_in;
                                r_idx   <= '0;
                                r_state <= S_LOAD;
                            end
                            pleg_pkg::MODE_RESTART: begin
                                r_counter <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_LOAD: begin
                    r_p0    <= rd_pos;
                    r_g0    <= rd_gain;
                    r_idx   <= IW'(1);
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (seg_hit) begin
                        r_p1    <= rd_pos;
                        r_g1    <= rd_gain;
                        r_state <= S_MUL;
                    end else if (r_idx == r_last) begin
                        r_y     <= r_s;
                        r_sat   <= 1'b0;
                        r_state <= S_PUSH;
                    end else begin
                        r_p0  <= rd_pos;
                        r_g0  <= rd_gain;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_MUL: begin
                    r_neg   <= gdiff[pleg_pkg::DIFF_W-1];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN: begin
                    r_g     <= gsum[GW-1:0];
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_sat <= ovf;
                    if (ovf) begin
                        r_y <= y[pleg_pkg::Y_W-1] ? {1'b1, {(SW-1){1'b0}}}
                                                  : {1'b0, {(SW-1){1'b1}}};
                    end else begin
                        r_y <= y[SW-1:0];
                    end
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (push_ok) begin
                        r_out_sample <= r_y;
                        r_out_sat    <= r_sat;
                        r_counter    <= r_counter + 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.saturated  = r_out_sat;

endmodule

`default_nettype wire
